FILE: rtl/sctg_pkg.sv
// Shared types and constants for the servo cosine trajectory generator.
// Used by sctg_div and servo_cosine_trajectory_generator_top; depends on nothing.

package sctg_pkg;

   // Field widths.
   localparam int ANGLE_W    = 14;
   localparam int TARGET_W   = 16;
   localparam int SPAN_W     = 17;
   localparam int PHASE_W    = 17;
   localparam int TIME_W     = 16;
   localparam int CODE_W     = 12;
   localparam int SERVO_W    = 4;
   localparam int EASE_W     = 17;
   localparam int MUL_W      = 17;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int REG_W      = 16;
   localparam int PULSE_W    = 16;
   localparam int CHAN_W     = 8;

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_INDEX_W = 2;

   // Angles are in 1/64 degree; phase is Q16 with 65536 meaning a finished move.
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 14'd11520;
   localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;

   // Constants for building the ease table, in Q30.
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned PI_Q30  = 64'd3373259426;

   // Register reset values.
   localparam logic [REG_W-1:0] DUTY_RESET   = 16'd2844;
   localparam logic [REG_W-1:0] OFFSET_RESET = 16'd500;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_DUTY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET = 2'd1;

   // Operation codes carried in req_tuser.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_PRESET = 1'b1;

   // Timer numbers in bits 11:8 of the channel code.
   localparam logic [3:0] TIMER_FIRST  = 4'd1;
   localparam logic [3:0] TIMER_SECOND = 4'd2;

   // One servo's stored state.
   typedef struct packed {
      logic        [ANGLE_W-1:0]  angle;
      logic signed [TARGET_W-1:0] target;
      logic signed [SPAN_W-1:0]   span;
      logic        [ANGLE_W-1:0]  origin;
      logic        [PHASE_W-1:0]  phase;
   } servo_entry_type;

   localparam servo_entry_type ENTRY_RESET = '{
      angle:  14'd0,
      target: -16'sd64,
      span:   17'sd0,
      origin: 14'd0,
      phase:  17'd0
   };

   // Divider control and status.
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Limits a signed angle to the range 0 to 180 degrees.
   function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [17:0] value);
      logic [ANGLE_W-1:0] result;
      if (value < 18'sd0) begin
         result = '0;
      end else if (value > $signed({4'b0000, ANGLE_MAX})) begin
         result = ANGLE_MAX;
      end else begin
         result = value[ANGLE_W-1:0];
      end
      return result;
   endfunction

endpackage

FILE: rtl/sctg_div.sv
// Serial restoring divider giving floor(65536 / divisor), one quotient bit per cycle.
// Depends on sctg_pkg for widths and the control and status structs.

module sctg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  sctg_pkg::div_ctrl_type    ctrl,
   output logic [sctg_pkg::PHASE_W-1:0] quotient,
   output sctg_pkg::div_status_type  status
);

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   localparam logic [4:0] LAST_STEP = 5'(sctg_pkg::PHASE_W - 1);

   div_state_type                      state_ff;
   logic                               done_ff;
   logic [4:0]                         cnt_ff;
   logic [sctg_pkg::TIME_W-1:0]        rem_ff;
   logic [sctg_pkg::TIME_W-1:0]        dvsr_ff;
   logic [sctg_pkg::PHASE_W-1:0]       quot_ff;

   logic [sctg_pkg::TIME_W:0]          rem_shift;
   logic                               fits;
   logic [sctg_pkg::TIME_W-1:0]        rem_in;
   logic [sctg_pkg::PHASE_W-1:0]       quot_in;

   // The dividend shifts out of the top of the quotient register as the
   // quotient bits shift in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[sctg_pkg::PHASE_W-1]};
      fits      = rem_shift >= {1'b0, dvsr_ff};
      rem_in    = fits ? sctg_pkg::TIME_W'(rem_shift - {1'b0, dvsr_ff})
                       : rem_shift[sctg_pkg::TIME_W-1:0];
      quot_in   = {quot_ff[sctg_pkg::PHASE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DIV_IDLE: begin
               if (ctrl.start) begin
                  state_ff <= DIV_RUN;
                  cnt_ff   <= LAST_STEP;
                  rem_ff   <= '0;
                  dvsr_ff  <= ctrl.divisor;
                  quot_ff  <= sctg_pkg::PHASE_ONE;
               end
            end
            DIV_RUN: begin
               rem_ff  <= rem_in;
               quot_ff <= quot_in;
               cnt_ff  <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= DIV_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = (state_ff == DIV_RUN);
   assign status.done = done_ff;

endmodule

FILE: rtl/servo_cosine_trajectory_generator_top.sv
// Servo cosine trajectory generator: per-servo state memory, ease table and sequencer.
// Depends on sctg_pkg and instantiates the serial divider sctg_div.

// One transaction on req_ is handled at a time and gives exactly one transaction on rsp_.
// A motion tick with a non-zero move time first waits on the one-bit-per-cycle phase
// divider, then walks the shared 17x17 multiplier through the ease table lookup, the
// scaling of the span and the PWM compare value. A tick with zero move time skips the
// divider, a preset or a tick at the target goes straight to the PWM compare value, and a
// servo index of NUM_SERVOS or more goes straight to the output. Each path waits longer
// in the output state while an earlier result still sits unread in the output
// register. The per-servo state sits in a single-port memory read at acceptance and
// written back as the result is registered; entries never written read as their reset
// values through a valid bit per servo, so no clearing pass is needed after reset. A
// finished result waits in the output register while the next transaction is accepted.

module servo_cosine_trajectory_generator_top #(
   parameter int NUM_SERVOS       = 16,
   parameter int EASE_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] servo_index, [19:4] goal_angle, [35:20] travel_time_ms, [47:36] channel_code
   input  logic [sctg_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] op
   input  logic                                req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [3:0] servo_echo, [17:4] angle_out, [33:18] pulse_count, [41:34] channel_index,
   // [47:42] zero
   output logic [sctg_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] timer_select, [1] write_valid
   output logic [sctg_pkg::RSP_TUSER_W-1:0]    rsp_tuser,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sctg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sctg_pkg::REG_W-1:0]          csr_data
);

   localparam int IDX_W  = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int ROM_AW = $clog2(EASE_TABLE_DEPTH + 1);
   localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(EASE_TABLE_DEPTH);

   typedef logic [sctg_pkg::EASE_W-1:0] ease_rom_type [0:EASE_TABLE_DEPTH];

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_POS,
      S_ROMRD,
      S_MUL0,
      S_MUL1,
      S_EASE,
      S_SCALE,
      S_ANGLE,
      S_PULSE,
      S_OUT
   } state_type;

   // One point of (1 - cos(pi i / D)) / 2 in Q16 by a truncated Horner series.
   function automatic logic [sctg_pkg::EASE_W-1:0] ease_point(input int unsigned i);
      longint unsigned th;
      longint unsigned u;
      longint unsigned h;
      longint unsigned e;
      th = sctg_pkg::PI_Q30 * 64'(i) / 64'(EASE_TABLE_DEPTH);
      u  = (th * th) >> 30;
      h  = sctg_pkg::ONE_Q30 - u / 64'd90;
      h  = sctg_pkg::ONE_Q30 - ((u * h) >> 30) / 64'd56;
      h  = sctg_pkg::ONE_Q30 - ((u * h) >> 30) / 64'd30;
      h  = sctg_pkg::ONE_Q30 - ((u * h) >> 30) / 64'd12;
      e  = ((u * h) >> 30) / 64'd4;
      return sctg_pkg::EASE_W'((e + 64'd8192) >> 14);
   endfunction

   // The upper half of the curve mirrors the lower half, which is filled first.
   function automatic ease_rom_type ease_rom_fill();
      ease_rom_type rom;
      int unsigned  i;
      for (i = 0; i <= EASE_TABLE_DEPTH; i++) begin
         if (2 * i <= EASE_TABLE_DEPTH) begin
            rom[i] = ease_point(i);
         end else begin
            rom[i] = sctg_pkg::PHASE_ONE - rom[EASE_TABLE_DEPTH - i];
         end
      end
      return rom;
   endfunction

   localparam ease_rom_type EASE_ROM = ease_rom_fill();

   // Control registers.
   state_type                          state_ff, state_in;
   logic [NUM_SERVOS-1:0]              valid_ff, valid_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [sctg_pkg::REG_W-1:0]         duty_ff, duty_in;
   logic [sctg_pkg::REG_W-1:0]         offset_ff, offset_in;

   // Payload registers.
   logic                               op_ff, op_in;
   logic                               bad_ff, bad_in;
   logic [sctg_pkg::SERVO_W-1:0]       sid_ff, sid_in;
   logic [IDX_W-1:0]                   addr_ff, addr_in;
   logic signed [sctg_pkg::TARGET_W-1:0] tgt_ff, tgt_in;
   logic [sctg_pkg::TIME_W-1:0]        tms_ff, tms_in;
   logic [sctg_pkg::CODE_W-1:0]        code_ff, code_in;
   logic [sctg_pkg::ANGLE_W-1:0]       angle_ff, angle_in;
   logic signed [sctg_pkg::TARGET_W-1:0] ltgt_ff, ltgt_in;
   logic signed [sctg_pkg::SPAN_W-1:0] span_ff, span_in;
   logic [sctg_pkg::ANGLE_W-1:0]       origin_ff, origin_in;
   logic [sctg_pkg::PHASE_W-1:0]       phase_ff, phase_in;
   logic [15:0]                        frac_ff, frac_in;
   logic [sctg_pkg::PROD_W-1:0]        acc_ff, acc_in;
   logic [sctg_pkg::PROD_W-1:0]        prod_ff;
   logic [sctg_pkg::EASE_W-1:0]        ease_ff, ease_in;
   logic [sctg_pkg::RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [sctg_pkg::RSP_TUSER_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   // Memories and their registered read data.
   sctg_pkg::servo_entry_type          state_mem [0:NUM_SERVOS-1];
   sctg_pkg::servo_entry_type          rd_entry_ff;
   sctg_pkg::servo_entry_type          wr_entry;
   logic [sctg_pkg::EASE_W-1:0]        rom0_ff;
   logic [sctg_pkg::EASE_W-1:0]        rom1_ff;

   // Datapath signals.
   logic                               req_accept;
   logic [sctg_pkg::SERVO_W-1:0]       req_servo;
   logic [IDX_W-1:0]                   req_addr;
   logic                               req_in_range;
   logic                               slot_free;
   logic                               mem_we;
   logic                               rom_rd;
   logic                               mul_en;
   logic [sctg_pkg::MUL_W-1:0]         mul_a;
   logic [sctg_pkg::MUL_W-1:0]         mul_b;
   sctg_pkg::servo_entry_type          entry_q;
   logic signed [sctg_pkg::SPAN_W-1:0] delta;
   logic [ROM_AW-1:0]                  rom_idx;
   logic [ROM_AW-1:0]                  rom_addr1;
   logic [sctg_pkg::PROD_W-1:0]        ease_sum;
   logic [sctg_pkg::SPAN_W-1:0]        mag;
   logic [32:0]                        round_sum;
   logic [sctg_pkg::SPAN_W-1:0]        step;
   logic signed [17:0]                 ang_sum;
   logic [sctg_pkg::PHASE_W:0]         phase_sum;
   logic [sctg_pkg::PHASE_W-1:0]       phase_sat;
   logic [sctg_pkg::PULSE_W:0]         pulse_sum;
   logic [sctg_pkg::PULSE_W-1:0]       pulse;
   logic                               timer_sel;
   logic                               write_ok;

   sctg_pkg::div_ctrl_type             div_ctrl;
   sctg_pkg::div_status_type           div_stat;
   logic [sctg_pkg::PHASE_W-1:0]       div_quot;

   sctg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_servo    = req_tdata[3:0];
   assign req_addr     = IDX_W'(req_servo);
   assign req_in_range = 32'(req_servo) < NUM_SERVOS;
   assign slot_free    = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready    = 1'b1;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Entries never written since reset read as the reset state.
   assign entry_q = valid_ff[addr_ff] ? rd_entry_ff : sctg_pkg::ENTRY_RESET;
   assign delta   = {tgt_ff[sctg_pkg::TARGET_W-1], tgt_ff} - {3'b000, entry_q.angle};

   // At full phase the index lands on the last entry with a zero fraction,
   // so the second read port is held there instead of running past the end.
   assign rom_idx   = prod_ff[16 +: ROM_AW];
   assign rom_addr1 = (rom_idx == ROM_LAST) ? rom_idx : rom_idx + 1'b1;

   assign ease_sum  = acc_ff + prod_ff;
   assign mag       = span_ff[sctg_pkg::SPAN_W-1] ? (~span_ff + 17'd1) : span_ff;
   assign round_sum = prod_ff[32:0] + 33'd32768;
   assign step      = round_sum[32:16];
   assign ang_sum   = span_ff[sctg_pkg::SPAN_W-1] ? ({4'b0000, origin_ff} - {1'b0, step})
                                                  : ({4'b0000, origin_ff} + {1'b0, step});

   assign phase_sum = {1'b0, phase_ff} + {1'b0, div_quot};
   assign phase_sat = (phase_sum > {1'b0, sctg_pkg::PHASE_ONE}) ? sctg_pkg::PHASE_ONE
                                                               : phase_sum[sctg_pkg::PHASE_W-1:0];

   assign pulse_sum = {1'b0, prod_ff[29:14]} + {1'b0, offset_ff};
   assign pulse     = pulse_sum[sctg_pkg::PULSE_W] ? '1 : pulse_sum[sctg_pkg::PULSE_W-1:0];

   assign wr_entry = '{
      angle:  angle_ff,
      target: ltgt_ff,
      span:   span_ff,
      origin: origin_ff,
      phase:  phase_ff
   };

   always_comb begin
      timer_sel = 1'b0;
      write_ok  = 1'b0;
      unique case (code_ff[11:8])
         sctg_pkg::TIMER_FIRST: begin
            write_ok = 1'b1;
         end
         sctg_pkg::TIMER_SECOND: begin
            timer_sel = 1'b1;
            write_ok  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      duty_in       = duty_ff;
      offset_in     = offset_ff;
      op_in         = op_ff;
      bad_in        = bad_ff;
      sid_in        = sid_ff;
      addr_in       = addr_ff;
      tgt_in        = tgt_ff;
      tms_in        = tms_ff;
      code_in       = code_ff;
      angle_in      = angle_ff;
      ltgt_in       = ltgt_ff;
      span_in       = span_ff;
      origin_in     = origin_ff;
      phase_in      = phase_ff;
      frac_in       = frac_ff;
      acc_in        = acc_ff;
      ease_in       = ease_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      div_ctrl      = '{start: 1'b0, divisor: tms_ff};
      mem_we        = 1'b0;
      rom_rd        = 1'b0;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sctg_pkg::REG_DUTY:   duty_in   = csr_data;
            sctg_pkg::REG_OFFSET: offset_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_tuser;
               sid_in   = req_servo;
               addr_in  = req_addr;
               tgt_in   = req_tdata[19:4];
               tms_in   = req_tdata[35:20];
               code_in  = req_tdata[47:36];
               bad_in   = !req_in_range;
               state_in = req_in_range ? S_READ : S_OUT;
            end
         end
         S_READ: begin
            angle_in  = entry_q.angle;
            ltgt_in   = entry_q.target;
            span_in   = entry_q.span;
            origin_in = entry_q.origin;
            phase_in  = entry_q.phase;
            if (op_ff == sctg_pkg::OP_PRESET) begin
               angle_in = sctg_pkg::clamp_angle({{2{tgt_ff[sctg_pkg::TARGET_W-1]}}, tgt_ff});
               state_in = S_PULSE;
            end else begin
               // A changed target starts a new move from the present angle.
               if (entry_q.target != tgt_ff) begin
                  span_in   = delta;
                  origin_in = entry_q.angle;
                  ltgt_in   = tgt_ff;
                  phase_in  = '0;
               end
               if (delta == '0) begin
                  phase_in = '0;
                  state_in = S_PULSE;
               end else if (tms_ff == '0) begin
                  phase_in = sctg_pkg::PHASE_ONE;
                  state_in = S_POS;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               phase_in = phase_sat;
               state_in = S_POS;
            end
         end
         S_POS: begin
            mul_en   = 1'b1;
            mul_a    = phase_ff;
            mul_b    = sctg_pkg::MUL_W'(EASE_TABLE_DEPTH);
            state_in = S_ROMRD;
         end
         S_ROMRD: begin
            rom_rd   = 1'b1;
            frac_in  = prod_ff[15:0];
            state_in = S_MUL0;
         end
         S_MUL0: begin
            mul_en   = 1'b1;
            mul_a    = rom0_ff;
            mul_b    = sctg_pkg::PHASE_ONE - {1'b0, frac_ff};
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = prod_ff;
            mul_en   = 1'b1;
            mul_a    = rom1_ff;
            mul_b    = {1'b0, frac_ff};
            state_in = S_EASE;
         end
         S_EASE: begin
            ease_in  = ease_sum[32:16];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            mul_en   = 1'b1;
            mul_a    = mag;
            mul_b    = ease_ff;
            state_in = S_ANGLE;
         end
         S_ANGLE: begin
            angle_in = sctg_pkg::clamp_angle(ang_sum);
            state_in = S_PULSE;
         end
         S_PULSE: begin
            mul_en   = 1'b1;
            mul_a    = {3'b000, angle_ff};
            mul_b    = {1'b0, duty_ff};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               if (bad_ff) begin
                  rsp_tdata_in = {44'd0, sid_ff};
                  rsp_tuser_in = '0;
               end else begin
                  rsp_tdata_in = {6'd0, code_ff[7:0], pulse, angle_ff, sid_ff};
                  rsp_tuser_in = {write_ok, timer_sel};
                  mem_we       = 1'b1;
                  valid_in[addr_ff] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         duty_ff       <= sctg_pkg::DUTY_RESET;
         offset_ff     <= sctg_pkg::OFFSET_RESET;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         duty_ff       <= duty_in;
         offset_ff     <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      bad_ff       <= bad_in;
      sid_ff       <= sid_in;
      addr_ff      <= addr_in;
      tgt_ff       <= tgt_in;
      tms_ff       <= tms_in;
      code_ff      <= code_in;
      angle_ff     <= angle_in;
      ltgt_ff      <= ltgt_in;
      span_ff      <= span_in;
      origin_ff    <= origin_in;
      phase_ff     <= phase_in;
      frac_ff      <= frac_in;
      acc_ff       <= acc_in;
      ease_ff      <= ease_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // The write-back of one transaction always lands before the next is
   // accepted, so a read never needs the entry still being written.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[addr_ff] <= wr_entry;
      end
      if (req_accept) begin
         rd_entry_ff <= state_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rom_rd) begin
         rom0_ff <= EASE_ROM[rom_idx];
         rom1_ff <= EASE_ROM[rom_addr1];
      end
   end

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == S_DIV)
      else $error("divider running outside the divide step");

   a_phase_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POS |-> phase_ff <= sctg_pkg::PHASE_ONE)
      else $error("phase above one at table lookup");

   a_angle_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PULSE |-> angle_ff <= sctg_pkg::ANGLE_MAX)
      else $error("angle above 180 degrees before scaling");

   a_writeback_emits: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> rsp_tvalid_ff)
      else $error("state written back without a result");

endmodule
